FILE: sv/kcw_pkg.sv
// shared constants, codes and item types for the knee/cut waveshaper
`timescale 1ns / 1ps
`default_nettype none

package kcw_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC           = SAMPLE_BITS - 1;
    localparam int KNEE_BITS      = SAMPLE_BITS - 1;
    localparam int CUT_BITS       = SAMPLE_BITS;
    localparam int CFG_DATA_BITS  = CUT_BITS;
    localparam int CFG_INDEX_BITS = 2;
    // |x|, |x|-knee and |cut-knee| reach 2^SAMPLE_BITS at most
    localparam int MAG_BITS       = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = 2 * SAMPLE_BITS + 1;
    localparam int NUM_BITS       = 2 * SAMPLE_BITS + 2;
    localparam int HI_BITS        = NUM_BITS - SAMPLE_BITS;
    localparam int NQ_BITS        = NUM_BITS - FRAC + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam longint ONE_L         = longint'(1) << FRAC;
    localparam longint KNEE_DEFAULT_L = (ONE_L + 5) / 10;
    localparam longint CUT_DEFAULT_L  = (3 * ONE_L + 5) / 10;
    localparam longint CUT_FLOOR_L    = (ONE_L + 50) / 100;

    localparam logic [KNEE_BITS-1:0] KNEE_DEFAULT = KNEE_BITS'(KNEE_DEFAULT_L);
    localparam logic [CUT_BITS-1:0]  CUT_DEFAULT  = CUT_BITS'(CUT_DEFAULT_L);
    localparam logic [CUT_BITS-1:0]  CUT_FLOOR    = CUT_BITS'(CUT_FLOOR_L);
    localparam logic [CUT_BITS-1:0]  CUT_MAX      = CUT_BITS'(ONE_L);
    localparam logic [SAMPLE_BITS:0] ONE_Q        = (SAMPLE_BITS+1)'(ONE_L);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KNEE_LEVEL  = 2'd0,
        REG_CUT_LEVEL   = 2'd1,
        REG_SOURCE_MODE = 2'd2,
        REG_MUTE_ENABLE = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_REGS        = 2'd0,
        MODE_BOTH_SAMPLE = 2'd1,
        MODE_KNEE_SAMPLE = 2'd2,
        MODE_CUT_SAMPLE  = 2'd3
    } source_mode_t;

    // classified item handed from the front to the back through the queue
    typedef struct packed {
        logic [PROD_BITS-1:0]   pm;
        logic [SAMPLE_BITS-1:0] kabs;
        logic                   neg_p;
        logic                   neg_k;
        logic                   x_le0;
        logic                   byp;
        logic [SAMPLE_BITS-1:0] bval;
        logic                   div;
        logic [SAMPLE_BITS-1:0] d;
    } item_t;

endpackage

`default_nettype wire

FILE: sv/kcw_front.sv
// front end: config registers, source select, classification and product
`timescale 1ns / 1ps
`default_nettype none

module kcw_front
    import kcw_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] audio_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] knee_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] cut_sample,
    output logic                               item_valid,
    output item_t                              item,
    input  wire logic                          item_ready
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] k;
        logic [SAMPLE_BITS:0]   c;
        logic                   mute;
    } s1_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]    a;
        logic [MAG_BITS-1:0]    bm;
        logic                   neg_p;
        logic                   neg_k;
        logic [SAMPLE_BITS-1:0] kabs;
        logic                   x_le0;
        logic                   byp;
        logic [SAMPLE_BITS-1:0] bval;
        logic                   div;
        logic [SAMPLE_BITS-1:0] d;
    } s2_t;

    logic [KNEE_BITS-1:0]   knee_level_reg;
    logic [CUT_BITS-1:0]    cut_level_reg;
    source_mode_t           source_mode_reg;
    logic                   mute_enable_reg;
    logic [CUT_BITS-1:0]    cut_write;
    logic [KNEE_BITS-1:0]   knee_write;

    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    s1_t                    s1_reg;
    s1_t                    s1_next;
    s2_t                    s2_reg;
    s2_t                    s2_next;
    logic                   adv;

    logic [MAG_BITS-1:0]    xe;
    logic [MAG_BITS-1:0]    m;
    logic [SAMPLE_BITS+1:0] me;
    logic [SAMPLE_BITS+1:0] ke;
    logic [SAMPLE_BITS+1:0] ce;
    logic [SAMPLE_BITS+1:0] a_full;
    logic [SAMPLE_BITS+1:0] diff;
    logic [SAMPLE_BITS+1:0] bm_full;
    logic [SAMPLE_BITS:0]   k17;
    logic [SAMPLE_BITS:0]   kabs_full;
    logic                   pass;
    logic [2*MAG_BITS-1:0]  prod_full;

    // knee and cut writes clamp into their legal ranges
    always_comb
    begin
        knee_write = cfg_data[KNEE_BITS-1:0];
        if (knee_write == '0)
        begin
            knee_write = KNEE_BITS'(1);
        end
        cut_write = cfg_data[CUT_BITS-1:0];
        if (cut_write == '0)
        begin
            cut_write = CUT_FLOOR;
        end
        else if (cut_write > CUT_MAX)
        begin
            cut_write = CUT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knee_level_reg  <= KNEE_DEFAULT;
            cut_level_reg   <= CUT_DEFAULT;
            source_mode_reg <= MODE_REGS;
            mute_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_KNEE_LEVEL:  knee_level_reg  <= knee_write;
                REG_CUT_LEVEL:   cut_level_reg   <= cut_write;
                REG_SOURCE_MODE: source_mode_reg <= source_mode_t'(cfg_data[1:0]);
                REG_MUTE_ENABLE: mute_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign adv      = !s2_valid_reg || item_ready;
    assign in_stall = !adv;

    always_comb
    begin
        s1_next.x    = audio_sample;
        s1_next.mute = mute_enable_reg;
        if (source_mode_reg inside {MODE_BOTH_SAMPLE, MODE_KNEE_SAMPLE})
        begin
            s1_next.k = knee_sample;
        end
        else
        begin
            s1_next.k = {1'b0, knee_level_reg};
        end
        if (source_mode_reg inside {MODE_BOTH_SAMPLE, MODE_CUT_SAMPLE})
        begin
            s1_next.c = {cut_sample[SAMPLE_BITS-1], cut_sample};
        end
        else
        begin
            s1_next.c = {1'b0, cut_level_reg};
        end
    end

    // magnitude, knee test and the two factors of the bend term
    always_comb
    begin
        xe        = {s1_reg.x[SAMPLE_BITS-1], s1_reg.x};
        m         = xe[SAMPLE_BITS] ? (~xe + MAG_BITS'(1)) : xe;
        me        = {1'b0, m};
        ke        = {{2{s1_reg.k[SAMPLE_BITS-1]}}, s1_reg.k};
        ce        = {s1_reg.c[SAMPLE_BITS], s1_reg.c};
        pass      = $signed(me) < $signed(ke);
        a_full    = me - ke;
        diff      = ce - ke;
        bm_full   = diff[SAMPLE_BITS+1] ? (~diff + (SAMPLE_BITS+2)'(1)) : diff;
        k17       = {s1_reg.k[SAMPLE_BITS-1], s1_reg.k};
        kabs_full = k17[SAMPLE_BITS] ? (~k17 + (SAMPLE_BITS+1)'(1)) : k17;

        s2_next.a     = a_full[MAG_BITS-1:0];
        s2_next.bm    = bm_full[MAG_BITS-1:0];
        s2_next.neg_p = diff[SAMPLE_BITS+1];
        s2_next.neg_k = s1_reg.k[SAMPLE_BITS-1];
        s2_next.kabs  = kabs_full[SAMPLE_BITS-1:0];
        // zero counts as negative for the output sign
        s2_next.x_le0 = s1_reg.x[SAMPLE_BITS-1] || (s1_reg.x == '0);
        s2_next.byp   = s1_reg.mute || pass;
        s2_next.bval  = s1_reg.mute ? '0 : s1_reg.x;
        s2_next.div   = !s1_reg.c[SAMPLE_BITS] && (s1_reg.c != '0);
        s2_next.d     = s1_reg.c[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign prod_full = s2_reg.a * s2_reg.bm;

    always_comb
    begin
        item.pm    = prod_full[PROD_BITS-1:0];
        item.kabs  = s2_reg.kabs;
        item.neg_p = s2_reg.neg_p;
        item.neg_k = s2_reg.neg_k;
        item.x_le0 = s2_reg.x_le0;
        item.byp   = s2_reg.byp;
        item.bval  = s2_reg.bval;
        item.div   = s2_reg.div;
        item.d     = s2_reg.d;
    end

    assign item_valid = s2_valid_reg;

endmodule

`default_nettype wire

FILE: sv/kcw_queue.sv
// short item queue between the front end and the divider back end
`timescale 1ns / 1ps
`default_nettype none

module kcw_queue
    import kcw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire item_t push_item,
    output logic       push_ready,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);

    item_t                     mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic [QUEUE_PTR_BITS:0]   count_next;
    logic                      push_fire;
    logic                      pop_fire;

    assign push_ready = count_reg != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/kcw_back.sv
// back end: numerator, pipelined restoring divider, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module kcw_back
    import kcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire item_t                  head_item,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    typedef struct packed {
        logic [NUM_BITS-1:0]    mag;
        logic                   neg_out;
        logic                   byp;
        logic [SAMPLE_BITS-1:0] bval;
        logic                   div;
        logic [SAMPLE_BITS-1:0] d;
    } num_t;

    typedef struct packed {
        logic                   neg_out;
        logic                   byp;
        logic [SAMPLE_BITS-1:0] bval;
        logic                   div;
        logic                   big;
        logic [SAMPLE_BITS-1:0] d;
        logic [SAMPLE_BITS-1:0] rem;
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] quo;
        logic [SAMPLE_BITS:0]   qn;
    } div_t;

    // one quotient bit per stage
    function automatic div_t div_step(input div_t s);
        div_t                 r;
        logic [SAMPLE_BITS:0] trial;
        logic [SAMPLE_BITS:0] dif;
        r     = s;
        trial = {s.rem, s.low[SAMPLE_BITS-1]};
        dif   = trial - {1'b0, s.d};
        r.low = {s.low[SAMPLE_BITS-2:0], 1'b0};
        if (trial >= {1'b0, s.d})
        begin
            r.rem = dif[SAMPLE_BITS-1:0];
            r.quo = {s.quo[SAMPLE_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[SAMPLE_BITS-1:0];
            r.quo = {s.quo[SAMPLE_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    logic                   adv;
    logic                   num_valid_reg;
    num_t                   num_reg;
    num_t                   num_next;
    logic [SAMPLE_BITS:0]   div_valid_reg;
    div_t                   div_reg  [SAMPLE_BITS+1];
    div_t                   div_next [SAMPLE_BITS+1];
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [SAMPLE_BITS-1:0] out_sample_next;

    logic [NUM_BITS-1:0]    pm_e;
    logic [NUM_BITS-1:0]    km_e;
    logic                   neg_num;
    logic [HI_BITS-1:0]     hi;
    logic [NQ_BITS-1:0]     nq;
    logic                   ovf;
    logic                   rnd;
    logic [SAMPLE_BITS:0]   qd;
    logic [SAMPLE_BITS:0]   q;
    logic [SAMPLE_BITS:0]   qs;
    logic [SAMPLE_BITS:0]   qneg;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && head_valid;

    // signed-magnitude numerator: knee*ONE + (|x|-knee)*(cut-knee)
    always_comb
    begin
        pm_e = NUM_BITS'(head_item.pm);
        km_e = NUM_BITS'(head_item.kabs) << FRAC;
        if (head_item.neg_p == head_item.neg_k)
        begin
            num_next.mag = pm_e + km_e;
            neg_num      = head_item.neg_p;
        end
        else if (pm_e >= km_e)
        begin
            num_next.mag = pm_e - km_e;
            neg_num      = head_item.neg_p;
        end
        else
        begin
            num_next.mag = km_e - pm_e;
            neg_num      = head_item.neg_k;
        end
        num_next.neg_out = neg_num != head_item.x_le0;
        num_next.byp     = head_item.byp;
        num_next.bval    = head_item.bval;
        num_next.div     = head_item.div;
        num_next.d       = head_item.d;
    end

    always_comb
    begin
        hi  = num_reg.mag[NUM_BITS-1:SAMPLE_BITS];
        // quotient would need more than SAMPLE_BITS bits: saturates anyway
        ovf = hi >= HI_BITS'(num_reg.d);
        // no division: scale back by FRAC with round half up
        nq  = NQ_BITS'(num_reg.mag[NUM_BITS-1:FRAC]) + NQ_BITS'(num_reg.mag[FRAC-1]);

        div_next[0].neg_out = num_reg.neg_out;
        div_next[0].byp     = num_reg.byp;
        div_next[0].bval    = num_reg.bval;
        div_next[0].div     = num_reg.div;
        div_next[0].big     = num_reg.div ? ovf : (nq > NQ_BITS'(ONE_L));
        div_next[0].d       = num_reg.d;
        div_next[0].rem     = hi[SAMPLE_BITS-1:0];
        div_next[0].low     = num_reg.mag[SAMPLE_BITS-1:0];
        div_next[0].quo     = '0;
        div_next[0].qn      = nq[SAMPLE_BITS:0];
        for (int i = 1; i <= SAMPLE_BITS; i++)
        begin
            div_next[i] = div_step(div_reg[i-1]);
        end
    end

    // round to nearest, sign and saturate
    always_comb
    begin
        rnd  = {div_reg[SAMPLE_BITS].rem, 1'b0} >= {1'b0, div_reg[SAMPLE_BITS].d};
        qd   = {1'b0, div_reg[SAMPLE_BITS].quo} + (SAMPLE_BITS+1)'(rnd);
        q    = div_reg[SAMPLE_BITS].div ? qd : div_reg[SAMPLE_BITS].qn;
        qs   = q;
        qneg = '0;
        if (div_reg[SAMPLE_BITS].byp)
        begin
            out_sample_next = div_reg[SAMPLE_BITS].bval;
        end
        else if (div_reg[SAMPLE_BITS].neg_out)
        begin
            if (div_reg[SAMPLE_BITS].big || (q > ONE_Q))
            begin
                qs = ONE_Q;
            end
            qneg            = ~qs + (SAMPLE_BITS+1)'(1);
            out_sample_next = qneg[SAMPLE_BITS-1:0];
        end
        else
        begin
            if (div_reg[SAMPLE_BITS].big || (q > ONE_Q - (SAMPLE_BITS+1)'(1)))
            begin
                qs = ONE_Q - (SAMPLE_BITS+1)'(1);
            end
            out_sample_next = qs[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            num_valid_reg <= pop;
            div_valid_reg <= {div_valid_reg[SAMPLE_BITS-1:0], num_valid_reg};
            out_valid_reg <= div_valid_reg[SAMPLE_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg        <= num_next;
            div_reg        <= div_next;
            out_sample_reg <= out_sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

`default_nettype wire

FILE: sv/knee_cut_waveshaper_core.sv
// knee_cut_waveshaper_core: items pass the front stages, the queue, the numerator
// register, the divider and the output register; one item per cycle when not stalled
// the divider has one stage per quotient bit, a 4-entry queue absorbs output stalls
// in_stall rises once the queue is full and the front stage holds an item
// reset empties the pipeline and restores knee 0.1, cut 0.3, mode 0, mute off
`timescale 1ns / 1ps
`default_nettype none

module knee_cut_waveshaper_core
    import kcw_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] audio_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] knee_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] cut_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      out_sample
);

    logic  front_valid;
    item_t front_item;
    logic  front_ready;
    logic  head_valid;
    item_t head_item;
    logic  head_pop;

    kcw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .audio_sample (audio_sample),
        .knee_sample  (knee_sample),
        .cut_sample   (cut_sample),
        .item_valid   (front_valid),
        .item         (front_item),
        .item_ready   (front_ready)
    );

    kcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    kcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (head_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample)
    );

endmodule

`default_nettype wire

FILE: dv/tb_knee_cut_waveshaper_core.sv
// self-checking testbench for the knee/cut waveshaper core
`timescale 1ns / 1ps

module tb_knee_cut_waveshaper_core;
    import kcw_pkg::*;

    localparam int ROWS         = 34;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 30;
    localparam int WATCHDOG_MAX = 2000;

    typedef enum logic [0:0] {
        ROW_ITEM  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    // one step of the directed table: a register write or an item
    typedef struct packed {
        row_kind_t                     kind;
        reg_index_t                    idx;
        logic [CFG_DATA_BITS-1:0]      data;
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SAMPLE_BITS-1:0] k;
        logic signed [SAMPLE_BITS-1:0] c;
        logic                          fixed;
        logic signed [SAMPLE_BITS-1:0] want;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] audio_sample = '0;
    logic signed [SAMPLE_BITS-1:0] knee_sample = '0;
    logic signed [SAMPLE_BITS-1:0] cut_sample = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    // shadow of the register file
    longint       knee_reg = KNEE_DEFAULT_L;
    longint       cut_reg = CUT_DEFAULT_L;
    source_mode_t mode = MODE_REGS;
    bit           mute = 1'b0;

    logic signed [SAMPLE_BITS-1:0] pending_out[$];
    logic signed [SAMPLE_BITS-1:0] front;
    int  failures = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_off_req = 1'b0;

    row_t steps [ROWS] = '{
        // reset settings: knee 3277, cut 9830
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd3276, 16'sd0, 16'sd0, 1'b1, 16'sd3276},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, -16'sd3276, 16'sd0, 16'sd0, 1'b1, -16'sd3276},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd3277, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        // mute
        '{ROW_WRITE, REG_MUTE_ENABLE, 16'h0001, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh7fff, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_MUTE_ENABLE, 16'hfffe, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        // knee and cut from the item
        '{ROW_WRITE, REG_SOURCE_MODE, 16'h0001, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd0, 16'sd0, 16'sd9830, 1'b1, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd0, -16'sd100, 16'sd9830, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh7fff, 16'sh7fff, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd20000, 16'sd100, 16'sh7fff, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, -16'sd1, 16'sh7fff, 16'sh7fff, 1'b1, -16'sd1},
        // high data bits are dropped, this selects knee from the item
        '{ROW_WRITE, REG_SOURCE_MODE, 16'hfffe, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd5000, 16'sd1000, -16'sd1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_SOURCE_MODE, 16'h0003, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd5000, 16'sd1000, -16'sd5, 1'b0, 16'sd0},
        // register clamps
        '{ROW_WRITE, REG_SOURCE_MODE, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_KNEE_LEVEL, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_CUT_LEVEL, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_KNEE_LEVEL, 16'hffff, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_CUT_LEVEL, 16'hffff, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sd32766, 16'sd0, 16'sd0, 1'b1, 16'sd32766},
        '{ROW_WRITE, REG_CUT_LEVEL, 16'h0001, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_ITEM, REG_KNEE_LEVEL, 16'h0, -16'sd32767, 16'sd0, 16'sd0, 1'b0, 16'sd0}
    };

    knee_cut_waveshaper_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .audio_sample (audio_sample),
        .knee_sample  (knee_sample),
        .cut_sample   (cut_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_sample   (out_sample)
    );

    always #6 clk = ~clk;

    function automatic logic signed [SAMPLE_BITS-1:0] shaped_sample(
        logic signed [SAMPLE_BITS-1:0] x,
        logic signed [SAMPLE_BITS-1:0] ks,
        logic signed [SAMPLE_BITS-1:0] cs
    );
        longint xl, k, c, m, a, b, pm, km, mag, q, r;
        bit neg_p, neg_k, neg_num, neg_out;
        xl = x;
        k = knee_reg;
        c = cut_reg;
        if (mode == MODE_BOTH_SAMPLE || mode == MODE_KNEE_SAMPLE)
            k = ks;
        if (mode == MODE_BOTH_SAMPLE || mode == MODE_CUT_SAMPLE)
            c = cs;
        if (mute)
            return '0;
        m = (xl < 0) ? -xl : xl;
        if (m < k)
            return x;
        // numerator knee*one + (|x|-knee)*(cut-knee) in sign-magnitude
        a = m - k;
        neg_p = (c - k) < 0;
        b = neg_p ? k - c : c - k;
        pm = a * b;
        neg_k = k < 0;
        km = (neg_k ? -k : k) * ONE_L;
        if (neg_p == neg_k)
        begin
            mag = pm + km;
            neg_num = neg_p;
        end
        else if (pm >= km)
        begin
            mag = pm - km;
            neg_num = neg_p;
        end
        else
        begin
            mag = km - pm;
            neg_num = neg_k;
        end
        // round half away from zero on the magnitude
        if (c > 0)
        begin
            q = mag / c;
            r = mag % c;
            if (r >= c - r)
                q++;
        end
        else
            q = (mag >>> FRAC) + ((mag >>> (FRAC - 1)) & 1);
        neg_out = neg_num != (xl <= 0);
        if (neg_out)
        begin
            if (q > ONE_L)
                q = ONE_L;
            return SAMPLE_BITS'(-q);
        end
        if (q > ONE_L - 1)
            q = ONE_L - 1;
        return SAMPLE_BITS'(q);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_field();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2: return SAMPLE_BITS'($urandom_range(0, 16000));
            3: return -SAMPLE_BITS'($urandom_range(0, 16000));
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_level();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return CFG_DATA_BITS'($urandom_range(1, 20000));
        endcase
    endfunction

    task automatic log_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    task automatic write_register(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_KNEE_LEVEL:
            begin
                knee_reg = data[KNEE_BITS-1:0];
                if (knee_reg == 0)
                    knee_reg = 1;
            end
            REG_CUT_LEVEL:
            begin
                if (data == 0)
                    cut_reg = CUT_FLOOR;
                else if (data > CUT_MAX)
                    cut_reg = CUT_MAX;
                else
                    cut_reg = data;
            end
            REG_SOURCE_MODE: mode = source_mode_t'(data[1:0]);
            REG_MUTE_ENABLE: mute = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one item, record its expected output once it is taken
    task automatic offer_sample(
        logic signed [SAMPLE_BITS-1:0] s,
        logic signed [SAMPLE_BITS-1:0] k,
        logic signed [SAMPLE_BITS-1:0] c,
        bit                            fixed,
        logic signed [SAMPLE_BITS-1:0] fixed_want
    );
        in_valid     <= 1'b1;
        audio_sample <= s;
        knee_sample  <= k;
        cut_sample   <= c;
        do
            @(posedge clk);
        while (in_stall);
        pending_out.push_back(fixed ? fixed_want : shaped_sample(s, k, c));
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    // output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_out.size() == 0)
                log_failure($sformatf("unexpected out_sample %0d", out_sample));
            else
            begin
                front = pending_out.pop_front();
                if (out_sample !== front)
                    log_failure($sformatf("out_sample mismatch: expected %0d, got %0d",
                                          front, out_sample));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_BITS-1:0] knee_data, cut_data;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROWS; i++)
        begin
            if (steps[i].kind == ROW_WRITE)
            begin
                wait_for_results();
                write_register(steps[i].idx, steps[i].data);
            end
            else
                offer_sample(steps[i].s, steps[i].k, steps[i].c, steps[i].fixed,
                             steps[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_results();
            idle_on = (ph < PHASES - 1);
            knee_data = (ph == 0) ? 16'h7fff : (ph == 1) ? 16'h0001 : random_level();
            cut_data  = (ph == 0) ? 16'h0001 : (ph == 1) ? 16'h8000 : random_level();
            write_register(REG_KNEE_LEVEL, knee_data);
            write_register(REG_CUT_LEVEL, cut_data);
            write_register(REG_SOURCE_MODE, {14'($urandom()), 2'(ph % 4)});
            write_register(REG_MUTE_ENABLE, {15'($urandom()), ph == 5});
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long output hold-off while items keep coming, so the input backs up
                if (ph == 2 && n == 10)
                    hold_off_req = 1'b1;
                // pause the input until the pipeline has emptied
                if (ph == 3 && n == 25)
                    wait_for_results();
                offer_sample(random_field(), random_field(), random_field(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending_out.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
